### rtl/kvac_pkg.sv
// shared types, widths, register indexes and helpers for the knn vote accuracy counter
// no dependencies
package kvac_pkg;

	localparam int LBL_W  = 8;
	localparam int REG_W  = 7;
	localparam int VOTE_W = 6;
	localparam int STAT_W = 32;
	localparam int CMP_W  = 10;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] CFG_K_NEIGHBORS = 2'd0;
	localparam logic [IDX_W-1:0] CFG_VOTE_COUNT  = 2'd1;
	localparam logic [IDX_W-1:0] CFG_NUM_CLASSES = 2'd2;

	localparam logic [REG_W-1:0] K_NEIGHBORS_RST = 7'd1;
	localparam logic [REG_W-1:0] VOTE_COUNT_RST  = 7'd1;
	localparam logic [REG_W-1:0] NUM_CLASSES_RST = 7'd64;

	// per-request control into the vote unit
	typedef struct packed {
		logic vote;
		logic bad;
		logic last;
	} vote_ctl_t;

	// per-query control into the statistics unit
	typedef struct packed {
		logic tok;
		logic correct;
	} stat_upd_t;

	function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
		sat_inc = (v == {STAT_W{1'b1}}) ? v : v + STAT_W'(1);
	endfunction

endpackage

### rtl/kvac_vote.sv
// vote counting: count/first-position memory, per-query seen bits and the running leader
// depends on kvac_pkg
module kvac_vote #(
	parameter int MAX_CLASSES   = 64,
	parameter int MAX_NEIGHBORS = 64
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     rd_en,
	input  logic [$clog2(MAX_CLASSES)-1:0]           rd_addr,
	input  logic                                     step,
	input  logic [$clog2(MAX_CLASSES)-1:0]           lbl,
	input  logic [((MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1)-1:0] pos,
	input  kvac_pkg::vote_ctl_t                      ctl,
	output logic [$clog2(MAX_CLASSES)-1:0]           lead_label,
	output logic                                     lead_valid,
	output logic                                     any_err
);

	localparam int CW = $clog2(MAX_CLASSES);
	localparam int PW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int NW = $clog2(MAX_NEIGHBORS + 1);
	localparam int EW = NW + PW;

	logic [EW-1:0] mem [MAX_CLASSES];
	logic [EW-1:0] rd_q;
	logic          fwd_we_q;
	logic [CW-1:0] fwd_addr_q;
	logic [EW-1:0] fwd_data_q;

	logic [MAX_CLASSES-1:0] seen_q;
	logic [CW-1:0] lead_lbl_q;
	logic [NW-1:0] lead_cnt_q;
	logic [PW-1:0] lead_first_q;
	logic          err_q;

	logic [EW-1:0] cur;
	logic          seen;
	logic [NW-1:0] base_cnt;
	logic [PW-1:0] base_first;
	logic [NW-1:0] cnt_n;
	logic [EW-1:0] wr_data;
	logic          take;
	logic [CW-1:0] nxt_lbl;
	logic [NW-1:0] nxt_cnt;
	logic [PW-1:0] nxt_first;

	always_comb begin
		// last write may not be visible in the registered read yet
		cur = (fwd_we_q && (fwd_addr_q == lbl)) ? fwd_data_q : rd_q;
		seen = seen_q[lbl];
		base_cnt = seen ? cur[EW-1:PW] : '0;
		base_first = seen ? cur[PW-1:0] : pos;
		cnt_n = base_cnt + NW'(1);
		wr_data = {cnt_n, base_first};
		take = (cnt_n > lead_cnt_q) ||
			((cnt_n == lead_cnt_q) && (lbl != lead_lbl_q) && (base_first < lead_first_q));
		nxt_lbl = lead_lbl_q;
		nxt_cnt = lead_cnt_q;
		nxt_first = lead_first_q;
		if (ctl.vote && take) begin
			nxt_lbl = lbl;
			nxt_first = base_first;
			if (cnt_n > lead_cnt_q) begin
				nxt_cnt = cnt_n;
			end
		end
		lead_label = nxt_lbl;
		lead_valid = (nxt_cnt != '0);
		any_err = err_q || ctl.bad;
	end

	always_ff @(posedge clk) begin
		if (step && ctl.vote) begin
			mem[lbl] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_we_q <= 1'b0;
			fwd_addr_q <= '0;
			fwd_data_q <= '0;
		end else if (rd_en) begin
			fwd_we_q <= step && ctl.vote;
			fwd_addr_q <= lbl;
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			lead_lbl_q <= '0;
			lead_cnt_q <= '0;
			lead_first_q <= '0;
			err_q <= 1'b0;
		end else if (step) begin
			if (ctl.last) begin
				seen_q <= '0;
				lead_lbl_q <= '0;
				lead_cnt_q <= '0;
				lead_first_q <= '0;
				err_q <= 1'b0;
			end else begin
				if (ctl.vote) begin
					seen_q[lbl] <= 1'b1;
				end
				lead_lbl_q <= nxt_lbl;
				lead_cnt_q <= nxt_cnt;
				lead_first_q <= nxt_first;
				if (ctl.bad) begin
					err_q <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/kvac_stats.sv
// accuracy bookkeeping: per-class total/correct memory with valid bits and the running total
// depends on kvac_pkg
module kvac_stats #(
	parameter int MAX_CLASSES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rd_en,
	input  logic [$clog2(MAX_CLASSES)-1:0]     rd_addr,
	input  logic                               step,
	input  logic [$clog2(MAX_CLASSES)-1:0]     idx,
	input  kvac_pkg::stat_upd_t                upd,
	output logic [kvac_pkg::STAT_W-1:0]        total_correct,
	output logic [kvac_pkg::STAT_W-1:0]        class_total,
	output logic [kvac_pkg::STAT_W-1:0]        class_hits
);

	localparam int CW = $clog2(MAX_CLASSES);
	localparam int SW = kvac_pkg::STAT_W;

	logic [2*SW-1:0] mem [MAX_CLASSES];
	logic [2*SW-1:0] rd_q;
	logic            fwd_we_q;
	logic [CW-1:0]   fwd_addr_q;
	logic [2*SW-1:0] fwd_data_q;
	logic [MAX_CLASSES-1:0] vld_q;
	logic [SW-1:0]   total_q;

	logic [2*SW-1:0] cur;
	logic [SW-1:0]   tot_n;
	logic [SW-1:0]   cor_n;
	logic            wr_en;

	always_comb begin
		if (!vld_q[idx]) begin
			cur = '0;
		end else if (fwd_we_q && (fwd_addr_q == idx)) begin
			cur = fwd_data_q;
		end else begin
			cur = rd_q;
		end
		tot_n = kvac_pkg::sat_inc(cur[2*SW-1:SW]);
		cor_n = upd.correct ? kvac_pkg::sat_inc(cur[SW-1:0]) : cur[SW-1:0];
		wr_en = step && upd.tok;
		total_correct = upd.correct ? kvac_pkg::sat_inc(total_q) : total_q;
		class_total = upd.tok ? tot_n : '0;
		class_hits = upd.tok ? cor_n : '0;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx] <= {tot_n, cor_n};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_we_q <= 1'b0;
			fwd_addr_q <= '0;
			fwd_data_q <= '0;
			vld_q <= '0;
			total_q <= '0;
		end else begin
			if (rd_en) begin
				fwd_we_q <= wr_en;
				fwd_addr_q <= idx;
				fwd_data_q <= {tot_n, cor_n};
			end
			if (wr_en) begin
				vld_q[idx] <= 1'b1;
			end
			if (step && upd.correct) begin
				total_q <= kvac_pkg::sat_inc(total_q);
			end
		end
	end

endmodule

### rtl/knn_vote_accuracy_counter.sv
// top level of the knn majority vote classifier with accuracy counters
// depends on kvac_pkg, kvac_vote and kvac_stats
//
// Neighbor labels of a query come in on the input channel (in_valid/in_ready), nearest
// first, one per request; true_label is used from the last neighbor of the query.
// After k_neighbors requests one result leaves on the output channel (out_valid/out_ready)
// with the vote, the correct flag and the running and per-class counts.
// Registers are written through cfg_wr_en/cfg_addr/cfg_wdata; the user must write them only
// while no query result is pending, which the block itself does not enforce; unknown indexes are ignored.
// Throughput: one neighbor per cycle while in_ready is high. Each label does a
// read-modify-write of the vote count memory (registered read, write-back from stage 1)
// with a one-entry forward of the last write; the last neighbor does the same on the
// per-class statistics memory. Its result passes stage 1, stage 2 and the output register.
// Reset loads the register defaults, clears the per-class valid bits and all query state;
// no clearing pass is needed, the block takes requests right after reset.
// When out_ready is low a finished result waits in the output register; later neighbors
// keep flowing until the next query's last neighbor reaches the final stage, then in_ready
// drops.
module knn_vote_accuracy_counter #(
	parameter int MAX_CLASSES   = 64,
	parameter int MAX_NEIGHBORS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [kvac_pkg::IDX_W-1:0]      cfg_addr,
	input  logic [kvac_pkg::REG_W-1:0]      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [kvac_pkg::LBL_W-1:0]      neighbor_label,
	input  logic [kvac_pkg::LBL_W-1:0]      true_label,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [kvac_pkg::VOTE_W-1:0]     voted_label,
	output logic                            is_correct,
	output logic                            label_error,
	output logic [kvac_pkg::STAT_W-1:0]     total_correct,
	output logic [kvac_pkg::STAT_W-1:0]     class_total,
	output logic [kvac_pkg::STAT_W-1:0]     class_hits
);

	localparam int CW = $clog2(MAX_CLASSES);
	localparam int PW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int XW = kvac_pkg::CMP_W;
	localparam logic [XW-1:0] MAXN = XW'(MAX_NEIGHBORS);
	localparam logic [XW-1:0] MAXC = XW'(MAX_CLASSES);

	logic [kvac_pkg::REG_W-1:0] k_q;
	logic [kvac_pkg::REG_W-1:0] votes_q;
	logic [kvac_pkg::REG_W-1:0] ncls_q;
	logic [PW-1:0] pos_q;

	logic [XW-1:0] k_raw, k_eff, v_raw, v_eff, n_raw, limit, pos_ext;
	logic vote_s0, last_s0, lbl_ok_s0, tok_s0;
	logic accept;

	logic v1_q, v2_q;
	logic [CW-1:0] lbl_s1, truth_s1, truth_s2, lead_s2;
	logic [PW-1:0] pos_s1;
	logic vote_s1, bad_s1, last_s1, tok_s1;
	logic last_s2, tok_s2, has_vote_s2, err_s2;
	logic out_free, adv1, adv2, step1, step2, correct_s2;

	logic [CW-1:0] lead_label;
	logic lead_valid, any_err;
	logic [kvac_pkg::STAT_W-1:0] tc_n, ct_n, cc_n;
	kvac_pkg::vote_ctl_t vctl;
	kvac_pkg::stat_upd_t supd;

	logic out_valid_q;
	logic [kvac_pkg::VOTE_W-1:0] voted_q;
	logic correct_q, err_q;
	logic [kvac_pkg::STAT_W-1:0] total_q, ctot_q, ccor_q;

	// register limits, clamped as the vote rules require
	always_comb begin
		k_raw = XW'(k_q);
		v_raw = XW'(votes_q);
		n_raw = XW'(ncls_q);
		k_eff = (k_raw == '0) ? XW'(1) : ((k_raw > MAXN) ? MAXN : k_raw);
		v_eff = (v_raw == '0) ? XW'(1) : ((v_raw > k_eff) ? k_eff : v_raw);
		limit = (n_raw < MAXC) ? n_raw : MAXC;
		pos_ext = XW'(pos_q);
		vote_s0 = pos_ext < v_eff;
		last_s0 = (pos_ext + XW'(1)) >= k_eff;
		lbl_ok_s0 = XW'(neighbor_label) < limit;
		tok_s0 = XW'(true_label) < limit;
	end

	always_comb begin
		out_free = !out_valid_q || out_ready;
		adv2 = !v2_q || !last_s2 || out_free;
		adv1 = !v1_q || adv2;
		in_ready = adv1;
		accept = in_valid && in_ready;
		step1 = v1_q && adv1;
		step2 = v2_q && last_s2 && adv2;
		correct_s2 = tok_s2 && has_vote_s2 && (lead_s2 == truth_s2);
		vctl = '{vote: vote_s1, bad: bad_s1, last: last_s1};
		supd = '{tok: tok_s2, correct: correct_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= kvac_pkg::K_NEIGHBORS_RST;
			votes_q <= kvac_pkg::VOTE_COUNT_RST;
			ncls_q <= kvac_pkg::NUM_CLASSES_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				kvac_pkg::CFG_K_NEIGHBORS: k_q <= cfg_wdata;
				kvac_pkg::CFG_VOTE_COUNT:  votes_q <= cfg_wdata;
				kvac_pkg::CFG_NUM_CLASSES: ncls_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q <= last_s0 ? '0 : pos_q + PW'(1);
			end
			if (adv1) begin
				v1_q <= in_valid;
			end
			if (adv2) begin
				v2_q <= v1_q;
				last_s2 <= v1_q && last_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			lbl_s1 <= neighbor_label[CW-1:0];
			truth_s1 <= true_label[CW-1:0];
			pos_s1 <= pos_q;
			vote_s1 <= vote_s0 && lbl_ok_s0;
			bad_s1 <= vote_s0 && !lbl_ok_s0;
			last_s1 <= last_s0;
			tok_s1 <= tok_s0;
		end
		if (adv2) begin
			lead_s2 <= lead_label;
			has_vote_s2 <= lead_valid;
			err_s2 <= any_err;
			truth_s2 <= truth_s1;
			tok_s2 <= tok_s1;
		end
	end

	kvac_vote #(
		.MAX_CLASSES  (MAX_CLASSES),
		.MAX_NEIGHBORS(MAX_NEIGHBORS)
	) u_vote (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (adv1),
		.rd_addr   (neighbor_label[CW-1:0]),
		.step      (step1),
		.lbl       (lbl_s1),
		.pos       (pos_s1),
		.ctl       (vctl),
		.lead_label(lead_label),
		.lead_valid(lead_valid),
		.any_err   (any_err)
	);

	kvac_stats #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_en        (adv2),
		.rd_addr      (truth_s1),
		.step         (step2),
		.idx          (truth_s2),
		.upd          (supd),
		.total_correct(tc_n),
		.class_total  (ct_n),
		.class_hits   (cc_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step2) begin
			voted_q <= has_vote_s2 ? kvac_pkg::VOTE_W'(lead_s2) : '0;
			correct_q <= correct_s2;
			err_q <= err_s2 || !tok_s2;
			total_q <= tc_n;
			ctot_q <= ct_n;
			ccor_q <= cc_n;
		end
	end

	assign out_valid = out_valid_q;
	assign voted_label = voted_q;
	assign is_correct = correct_q;
	assign label_error = err_q;
	assign total_correct = total_q;
	assign class_total = ctot_q;
	assign class_hits = ccor_q;

	a_correct_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_correct |-> (class_hits != '0) && (class_total >= class_hits))
		else $error("correct result without per-class count");

	a_class_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> class_hits <= total_correct)
		else $error("per-class correct count exceeds running total");

	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_s0 |=> pos_q == '0)
		else $error("neighbor position not restarted after last neighbor");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(v2_q && last_s2))
		else $error("result raised without a finished query");

endmodule

### tb/sv/knn_vote_accuracy_counter_tb.sv
// self-checking testbench for the knn vote accuracy counter
// a directed table, then random query streams checked against an in-bench predictor
// depends on kvac_pkg and knn_vote_accuracy_counter
module knn_vote_accuracy_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LBL_W  = kvac_pkg::LBL_W;
	localparam int REG_W  = kvac_pkg::REG_W;
	localparam int VOTE_W = kvac_pkg::VOTE_W;
	localparam int STAT_W = kvac_pkg::STAT_W;
	localparam int IDX_W  = kvac_pkg::IDX_W;

	localparam int MAX_CL = 64;
	localparam int MAX_NB = 64;
	localparam int SETTLE = 6;
	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 400;
	localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [VOTE_W-1:0] voted;
		logic              hit;
		logic              err;
		logic [STAT_W-1:0] total;
		logic [STAT_W-1:0] ctot;
		logic [STAT_W-1:0] ccor;
	} verdict_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_CHECK} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [IDX_W-1:0]  addr;
		logic [REG_W-1:0]  data;
		logic [LBL_W-1:0]  lbl;
		logic [LBL_W-1:0]  truth;
		verdict_t          want;
	} row_t;

	localparam verdict_t NO_V = '0;
	localparam int N_ROWS = 40;

	// typed results only where they follow directly from reset values or extremes
	localparam row_t PLAN [N_ROWS] = '{
		'{ROW_CHECK, 2'd0, 7'd0, 8'd5, 8'd5, '{6'd5, 1'b1, 1'b0, 32'd1, 32'd1, 32'd1}},
		'{ROW_CHECK, 2'd0, 7'd0, 8'd63, 8'd0, '{6'd63, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
		'{ROW_CHECK, 2'd0, 7'd0, 8'd255, 8'd63, '{6'd0, 1'b0, 1'b1, 32'd1, 32'd1, 32'd0}},
		'{ROW_CHECK, 2'd0, 7'd0, 8'd0, 8'd255, '{6'd0, 1'b0, 1'b1, 32'd1, 32'd0, 32'd0}},
		'{ROW_CFG, kvac_pkg::CFG_K_NEIGHBORS, 7'd3, 8'd0, 8'd0, NO_V},
		'{ROW_CFG, kvac_pkg::CFG_VOTE_COUNT, 7'd3, 8'd0, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd7, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd9, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd9, 8'd9, NO_V},
		'{ROW_CFG, kvac_pkg::CFG_K_NEIGHBORS, 7'd4, 8'd0, 8'd0, NO_V},
		'{ROW_CFG, kvac_pkg::CFG_VOTE_COUNT, 7'd4, 8'd0, 8'd0, NO_V},
		// two-two tie, the class seen first wins
		'{ROW_ITEM, 2'd0, 7'd0, 8'd3, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd8, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd8, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd3, 8'd3, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd8, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd3, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd3, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd8, 8'd3, NO_V},
		// only the two nearest vote
		'{ROW_CFG, kvac_pkg::CFG_VOTE_COUNT, 7'd2, 8'd0, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd1, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd2, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd2, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd2, 8'd2, NO_V},
		// out-of-range registers clamp to one neighbor, one vote
		'{ROW_CFG, kvac_pkg::CFG_K_NEIGHBORS, 7'd0, 8'd0, 8'd0, NO_V},
		'{ROW_CFG, kvac_pkg::CFG_VOTE_COUNT, 7'd5, 8'd0, 8'd0, NO_V},
		'{ROW_CHECK, 2'd0, 7'd0, 8'd4, 8'd4, '{6'd4, 1'b1, 1'b0, 32'd4, 32'd1, 32'd1}},
		// no valid class at all
		'{ROW_CFG, kvac_pkg::CFG_NUM_CLASSES, 7'd0, 8'd0, 8'd0, NO_V},
		'{ROW_CHECK, 2'd0, 7'd0, 8'd0, 8'd0, '{6'd0, 1'b0, 1'b1, 32'd4, 32'd0, 32'd0}},
		'{ROW_CFG, kvac_pkg::CFG_NUM_CLASSES, 7'd127, 8'd0, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd63, 8'd63, NO_V},
		'{ROW_CFG, CFG_SPARE, 7'd9, 8'd0, 8'd0, NO_V},
		// shorten the query while it is half done
		'{ROW_CFG, kvac_pkg::CFG_K_NEIGHBORS, 7'd4, 8'd0, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd10, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd11, 8'd0, NO_V},
		'{ROW_CFG, kvac_pkg::CFG_K_NEIGHBORS, 7'd2, 8'd0, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd12, 8'd10, NO_V},
		'{ROW_CFG, kvac_pkg::CFG_NUM_CLASSES, 7'd1, 8'd0, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd0, 8'd0, NO_V},
		'{ROW_ITEM, 2'd0, 7'd0, 8'd1, 8'd0, NO_V}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]   cfg_addr = '0;
	logic [REG_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [LBL_W-1:0]   neighbor_label = '0;
	logic [LBL_W-1:0]   true_label = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [VOTE_W-1:0]  voted_label;
	logic               is_correct;
	logic               label_error;
	logic [STAT_W-1:0]  total_correct;
	logic [STAT_W-1:0]  class_total;
	logic [STAT_W-1:0]  class_hits;

	knn_vote_accuracy_counter u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.neighbor_label (neighbor_label),
		.true_label     (true_label),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.voted_label    (voted_label),
		.is_correct     (is_correct),
		.label_error    (label_error),
		.total_correct  (total_correct),
		.class_total    (class_total),
		.class_hits     (class_hits)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [REG_W-1:0]  reg_k = kvac_pkg::K_NEIGHBORS_RST;
	logic [REG_W-1:0]  reg_votes = kvac_pkg::VOTE_COUNT_RST;
	logic [REG_W-1:0]  reg_classes = kvac_pkg::NUM_CLASSES_RST;
	int unsigned       tally [MAX_CL];
	int unsigned       first_pos [MAX_CL];
	bit                seen [MAX_CL];
	int unsigned       lead_lbl, lead_cnt, lead_first, nb_pos;
	bit                nb_err;
	logic [STAT_W-1:0] correct_cnt = '0;
	logic [STAT_W-1:0] cls_total [MAX_CL];
	logic [STAT_W-1:0] cls_correct [MAX_CL];

	verdict_t verdict_q [$];
	int       fails = 0;
	int       items_sent = 0;
	bit       tx_steady = 1'b0;
	bit       rx_steady = 1'b0;
	int       rx_hold = 0;
	int       idle_cycles = 0;

	function automatic logic [STAT_W-1:0] sat_bump(input logic [STAT_W-1:0] x);
		return (x == '1) ? x : x + 1'b1;
	endfunction

	function automatic void clear_query();
		for (int c = 0; c < MAX_CL; c++) begin
			tally[c] = 0;
			seen[c] = 1'b0;
		end
		lead_lbl = 0;
		lead_cnt = 0;
		lead_first = 0;
		nb_pos = 0;
		nb_err = 1'b0;
	endfunction

	// advances the predictor by one neighbor, returns 1 when the query finishes
	function automatic bit predict_neighbor(input logic [LBL_W-1:0] lbl,
			input logic [LBL_W-1:0] truth, output verdict_t v);
		int unsigned k, votes, lim, n;
		bit bad_truth, hit;
		k = reg_k;
		if (k < 1) k = 1;
		if (k > MAX_NB) k = MAX_NB;
		votes = reg_votes;
		if (votes < 1) votes = 1;
		if (votes > k) votes = k;
		lim = (reg_classes < MAX_CL) ? reg_classes : MAX_CL;
		v = '0;
		if (nb_pos < votes) begin
			if (lbl < lim) begin
				if (!seen[lbl]) begin
					seen[lbl] = 1'b1;
					first_pos[lbl] = nb_pos;
				end
				n = tally[lbl] + 1;
				tally[lbl] = n;
				if (n > lead_cnt) begin
					lead_lbl = lbl;
					lead_cnt = n;
					lead_first = first_pos[lbl];
				end else if (n == lead_cnt && lbl != lead_lbl &&
						first_pos[lbl] < lead_first) begin
					lead_lbl = lbl;
					lead_first = first_pos[lbl];
				end
			end else begin
				nb_err = 1'b1;
			end
		end
		if (nb_pos + 1 < k) begin
			nb_pos = nb_pos + 1;
			return 1'b0;
		end
		bad_truth = truth >= lim;
		hit = !bad_truth && lead_cnt > 0 && lead_lbl == truth;
		if (hit) correct_cnt = sat_bump(correct_cnt);
		if (!bad_truth) begin
			cls_total[truth] = sat_bump(cls_total[truth]);
			if (hit) cls_correct[truth] = sat_bump(cls_correct[truth]);
			v.ctot = cls_total[truth];
			v.ccor = cls_correct[truth];
		end
		v.voted = (lead_cnt > 0) ? VOTE_W'(lead_lbl) : '0;
		v.hit = hit;
		v.err = bad_truth || nb_err;
		v.total = correct_cnt;
		clear_query();
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_steady || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// result side: random stalls, some of them long
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			rx_hold <= ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{voted_label, is_correct, label_error, total_correct, class_total,
				class_hits};
			if (verdict_q.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("%0t: result with none expected: vote=%0d ok=%b err=%b tot=%0d",
						$realtime, got.voted, got.hit, got.err, got.total);
			end else begin
				want = verdict_q.pop_front();
				if (got !== want) begin
					fails++;
					if (fails <= 10) begin
						$display("%0t: mismatch, expected vote=%0d ok=%b err=%b tot=%0d cls=%0d/%0d",
							$realtime, want.voted, want.hit, want.err, want.total, want.ccor,
							want.ctot);
						$display("%0t:              got vote=%0d ok=%b err=%b tot=%0d cls=%0d/%0d",
							$realtime, got.voted, got.hit, got.err, got.total, got.ccor,
							got.ctot);
					end
				end
			end
		end
	end

	// ends a hung run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("** knn_vote_accuracy_counter: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_neighbor(input logic [LBL_W-1:0] lbl, input logic [LBL_W-1:0] truth,
			input bit typed, input verdict_t typed_v);
		int gap;
		verdict_t v;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		neighbor_label <= lbl;
		true_label <= truth;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		if (predict_neighbor(lbl, truth, v))
			verdict_q = {verdict_q, (typed ? typed_v : v)};
	endtask

	// stop requests and wait for every pending result, then let the pipe empty
	task automatic quiesce(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			kvac_pkg::CFG_K_NEIGHBORS: reg_k = val;
			kvac_pkg::CFG_VOTE_COUNT:  reg_votes = val;
			kvac_pkg::CFG_NUM_CLASSES: reg_classes = val;
			default: ;
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// one full query; labels mostly drawn from a few classes so ties and hits happen
	task automatic run_query();
		int unsigned k, lim, npool, r;
		logic [LBL_W-1:0] pool [3];
		logic [LBL_W-1:0] lbl, truth;
		bit noisy;
		k = reg_k;
		if (k < 1) k = 1;
		if (k > MAX_NB) k = MAX_NB;
		lim = (reg_classes < MAX_CL) ? reg_classes : MAX_CL;
		npool = $urandom_range(1, 3);
		for (int j = 0; j < 3; j++)
			pool[j] = (lim > 0) ? LBL_W'($urandom_range(0, lim - 1)) :
				LBL_W'($urandom_range(0, 255));
		noisy = $urandom_range(0, 9) < 2;
		for (int p = 0; p < k; p++) begin
			r = $urandom_range(0, 99);
			if (noisy || r >= 85) lbl = LBL_W'($urandom_range(0, 255));
			else lbl = pool[$urandom_range(0, npool - 1)];
			r = $urandom_range(0, 99);
			if (p != k - 1 || r >= 85) truth = LBL_W'($urandom_range(0, 255));
			else if (r < 65 || lim == 0) truth = pool[$urandom_range(0, npool - 1)];
			else truth = LBL_W'($urandom_range(0, lim - 1));
			send_neighbor(lbl, truth, 1'b0, NO_V);
		end
	endtask

	initial begin
		int unsigned sel, k_val, k_eff;
		int base, phase_start;
		bit forced_pause;
		clear_query();
		for (int c = 0; c < MAX_CL; c++) begin
			first_pos[c] = 0;
			cls_total[c] = '0;
			cls_correct[c] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (PLAN[i].kind == ROW_CFG) begin
				quiesce(SETTLE);
				reg_write(PLAN[i].addr, PLAN[i].data);
			end else begin
				send_neighbor(PLAN[i].lbl, PLAN[i].truth, PLAN[i].kind == ROW_CHECK,
					PLAN[i].want);
			end
		end

		base = items_sent;
		forced_pause = 1'b1;
		while (items_sent - base < RANDOM_ITEMS) begin
			quiesce(SETTLE);
			sel = $urandom_range(0, 19);
			if (sel == 0) k_val = 0;
			else if (sel == 1) k_val = 127;
			else if (sel == 2) k_val = 64;
			else if (sel < 6) k_val = $urandom_range(9, 24);
			else k_val = $urandom_range(1, 8);
			k_eff = (k_val < 1) ? 1 : (k_val > MAX_NB) ? MAX_NB : k_val;
			reg_write(kvac_pkg::CFG_K_NEIGHBORS, REG_W'(k_val));
			sel = $urandom_range(0, 9);
			if (sel == 0) reg_write(kvac_pkg::CFG_VOTE_COUNT, 7'd0);
			else if (sel == 1) reg_write(kvac_pkg::CFG_VOTE_COUNT, 7'd127);
			else if (sel == 2) reg_write(kvac_pkg::CFG_VOTE_COUNT, REG_W'(k_val));
			else reg_write(kvac_pkg::CFG_VOTE_COUNT, REG_W'($urandom_range(1, k_eff)));
			sel = $urandom_range(0, 9);
			if (sel == 0) reg_write(kvac_pkg::CFG_NUM_CLASSES, 7'd0);
			else if (sel == 1) reg_write(kvac_pkg::CFG_NUM_CLASSES, 7'd127);
			else if (sel == 2) reg_write(kvac_pkg::CFG_NUM_CLASSES, 7'd1);
			else if (sel == 3) reg_write(kvac_pkg::CFG_NUM_CLASSES, 7'd64);
			else reg_write(kvac_pkg::CFG_NUM_CLASSES, REG_W'($urandom_range(2, 12)));
			if ($urandom_range(0, 3) == 0)
				reg_write(CFG_SPARE, REG_W'($urandom_range(0, 127)));
			tx_steady = $urandom_range(0, 4) == 0;
			rx_steady = $urandom_range(0, 4) == 0;
			phase_start = items_sent;
			do begin
				run_query();
				// sender holds off until the result side has caught up
				if (forced_pause || $urandom_range(0, 11) == 0) begin
					quiesce(0);
					forced_pause = 1'b0;
				end
			end while (items_sent - phase_start < 40);
		end

		quiesce(SETTLE);
		if (verdict_q.size() != 0) fails++;
		if (fails == 0)
			$display("** knn_vote_accuracy_counter: PASSED **");
		else
			$display("** knn_vote_accuracy_counter: FAILED **");
		$finish;
	end

endmodule
